/* src/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is active.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/sgb_pkg.sv */
`default_nettype none

package sgb_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned PixW      = 16;
  localparam int unsigned RowW      = 16;
  localparam int unsigned WidthRegW = 9;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [16:0] CoefInCentre   = 17'd22137;
  localparam logic [15:0] CoefInSide     = 16'd21699;
  localparam logic [16:0] CoefEdgeCentre = 17'd33096;
  localparam logic [15:0] CoefEdgeSide   = 16'd32440;
  localparam logic [16:0] CoefPassCentre = 17'd65536;
  localparam logic [15:0] CoefPassSide   = 16'd0;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    TAP_VERT = 2'd0,
    TAP_H1   = 2'd1,
    TAP_H2   = 2'd2
  } tap_sel_e;

  typedef struct packed {
    logic            kind;
    logic [PixW-1:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [PixW-1:0]  pixel_out;
    logic [RowW-1:0]  row_index;
    logic [AddrW-1:0] col_index;
    logic             frame_end;
  } out_req_t;

  typedef struct packed {
    logic             ld_in;
    logic [AddrW-1:0] addr;
    tap_sel_e         tap;
    logic             has_a;
    logic             has_b;
    logic             mul_c;
    logic             mul_s;
    logic             ld_v;
    logic             ld_out;
    logic             mem_wr;
    logic             hist_shift;
    logic             hist_clr;
    logic [RowW-1:0]  out_row;
    logic [AddrW-1:0] out_col;
    logic             out_fe;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/sgb_datapath.sv */
`default_nettype none

`include "assert_macros.svh"

module sgb_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sgb_pkg::in_req_t  in_req_i,
  input  wire sgb_pkg::cmd_t     cmd_i,
  output sgb_pkg::sts_t          sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sgb_pkg::out_req_t      out_req_o
);

  localparam int unsigned PixW  = sgb_pkg::PixW;
  localparam int unsigned AddrW = sgb_pkg::AddrW;
  localparam int unsigned AccW  = 2 * PixW + 2;
  localparam int unsigned ProdW = 2 * PixW + 1;

  logic [2*PixW-1:0]  line_mem [sgb_pkg::MaxWidth];
  logic [2*PixW-1:0]  rd_q;
  logic [PixW-1:0]    pix_q;
  logic [AddrW-1:0]   addr_q;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [PixW-1:0]    v_q;
  logic [PixW-1:0]    hist0_q, hist1_q;
  logic               out_valid_q;
  sgb_pkg::out_req_t  out_q;

  logic [PixW-1:0]    centre, side_a, side_b;
  logic [PixW:0]      side_sum;
  logic [16:0]        coef_c;
  logic [15:0]        coef_s;
  logic [ProdW-1:0]   prod_c, prod_s;
  logic [AccW-1:0]    acc_rnd;
  logic [PixW-1:0]    rnd_sat;

  always_comb begin
    case (cmd_i.tap)
      sgb_pkg::TAP_VERT: begin
        centre = rd_q[PixW-1:0];
        side_a = rd_q[2*PixW-1:PixW];
        side_b = pix_q;
      end
      sgb_pkg::TAP_H1: begin
        centre = hist1_q;
        side_a = hist0_q;
        side_b = v_q;
      end
      sgb_pkg::TAP_H2: begin
        centre = v_q;
        side_a = hist1_q;
        side_b = '0;
      end
      default: begin
        centre = '0;
        side_a = '0;
        side_b = '0;
      end
    endcase
  end

  assign side_sum = (cmd_i.has_a ? {1'b0, side_a} : '0) + (cmd_i.has_b ? {1'b0, side_b} : '0);

  always_comb begin
    case ({cmd_i.has_a, cmd_i.has_b})
      2'b11: begin
        coef_c = sgb_pkg::CoefInCentre;
        coef_s = sgb_pkg::CoefInSide;
      end
      2'b10, 2'b01: begin
        coef_c = sgb_pkg::CoefEdgeCentre;
        coef_s = sgb_pkg::CoefEdgeSide;
      end
      default: begin
        coef_c = sgb_pkg::CoefPassCentre;
        coef_s = sgb_pkg::CoefPassSide;
      end
    endcase
  end

  assign prod_c = {{(ProdW-17){1'b0}}, coef_c} * {{(ProdW-PixW){1'b0}}, centre};
  assign prod_s = {{(ProdW-16){1'b0}}, coef_s} * {{(ProdW-PixW-1){1'b0}}, side_sum};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_c) begin
      acc_d = {{(AccW-ProdW){1'b0}}, prod_c};
    end else if (cmd_i.mul_s) begin
      acc_d = acc_q + {{(AccW-ProdW){1'b0}}, prod_s};
    end
  end

  assign acc_rnd = acc_q + AccW'(32768);
  assign rnd_sat = (|acc_rnd[AccW-1:2*PixW]) ? {PixW{1'b1}} : acc_rnd[2*PixW-1:PixW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      rd_q   <= line_mem[cmd_i.addr];
      pix_q  <= in_req_i.pixel_in;
      addr_q <= cmd_i.addr;
    end
    if (cmd_i.mem_wr) begin
      line_mem[addr_q] <= {rd_q[PixW-1:0], pix_q};
    end
    acc_q <= acc_d;
    if (cmd_i.ld_v) begin
      v_q <= rnd_sat;
    end
    if (cmd_i.ld_out) begin
      out_q.pixel_out <= rnd_sat;
      out_q.row_index <= cmd_i.out_row;
      out_q.col_index <= cmd_i.out_col;
      out_q.frame_end <= cmd_i.out_fe;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q     <= '0;
      hist1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hist_clr) begin
        hist0_q <= '0;
        hist1_q <= '0;
      end else if (cmd_i.hist_shift) begin
        hist0_q <= hist1_q;
        hist1_q <= v_q;
      end
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_req_o      = out_q;

  `ASSERT_CLK(a_out_valid_from_load, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.ld_out), "Result shown without a load command.")
  `ASSERT_CLK(a_mul_exclusive, clk_i, rst_ni, !(cmd_i.mul_c && cmd_i.mul_s), "Centre and side products requested together.")
  `ASSERT_CLK(a_out_held, clk_i, rst_ni, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)), "Waiting result changed before it was taken.")

endmodule

`default_nettype wire

/* src/sgb_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module sgb_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             in_kind_i,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_idx_i,
  input  wire logic [sgb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire sgb_pkg::sts_t                    sts_i,
  output sgb_pkg::cmd_t                         cmd_o
);

  localparam int unsigned AddrW = sgb_pkg::AddrW;
  localparam int unsigned RowW  = sgb_pkg::RowW;
  localparam int unsigned WW    = sgb_pkg::WidthRegW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_VC   = 11'b000_0000_0010,
    S_VS   = 11'b000_0000_0100,
    S_VR   = 11'b000_0000_1000,
    S_H1C  = 11'b000_0001_0000,
    S_H1S  = 11'b000_0010_0000,
    S_H1O  = 11'b000_0100_0000,
    S_H2C  = 11'b000_1000_0000,
    S_H2S  = 11'b001_0000_0000,
    S_H2O  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [WW-1:0]    width_q;
  logic [RowW-1:0]  height_q;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [AddrW-1:0] drain_q, drain_d;
  logic             kind_q, kind_d;
  logic             vert_q, vert_d;

  logic [WW-1:0]    w_eff;
  logic [RowW-1:0]  h_eff;
  logic             kind_cur;
  logic [AddrW-1:0] cur;
  logic             last;
  logic [RowW-1:0]  rv;
  logic             accept;
  logic             work;

  assign w_eff    = (width_q == '0) ? WW'(1) :
                    (width_q > WW'(sgb_pkg::MaxWidth)) ? WW'(sgb_pkg::MaxWidth) : width_q;
  assign h_eff    = (height_q == '0) ? RowW'(1) : height_q;
  assign kind_cur = (state_q == S_IDLE) ? in_kind_i : kind_q;
  assign cur      = (kind_cur == sgb_pkg::KIND_DRAIN) ? drain_q : col_q;
  assign last     = (WW'(cur) + WW'(1)) >= w_eff;
  assign rv       = (kind_q == sgb_pkg::KIND_DRAIN) ? h_eff - RowW'(1) : row_q - RowW'(1);
  assign accept   = in_valid_i && in_ready_o;
  assign work     = (in_kind_i == sgb_pkg::KIND_DRAIN) ? (row_q >= h_eff) : (row_q < h_eff);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    drain_d = drain_q;
    kind_d  = kind_q;
    vert_d  = vert_q;

    cmd_o            = '0;
    cmd_o.addr       = cur;
    cmd_o.tap        = sgb_pkg::TAP_VERT;
    cmd_o.out_row    = rv;
    cmd_o.out_col    = cur - AddrW'(1);
    cmd_o.out_fe     = 1'b0;

    case (state_q)
      S_IDLE: begin
        cmd_o.ld_in = accept;
        if (accept && work) begin
          kind_d = in_kind_i;
          vert_d = (in_kind_i == sgb_pkg::KIND_DRAIN) || (row_q != '0);
          if ((in_kind_i == sgb_pkg::KIND_DRAIN) || (row_q != '0)) begin
            state_d = S_VC;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_VC, S_VS, S_VR: begin
        cmd_o.tap   = sgb_pkg::TAP_VERT;
        cmd_o.has_b = (kind_q == sgb_pkg::KIND_PIXEL);
        cmd_o.has_a = (kind_q == sgb_pkg::KIND_DRAIN) ? (h_eff >= RowW'(2))
                                                      : (row_q >= RowW'(2));
        if (state_q == S_VC) begin
          cmd_o.mul_c = 1'b1;
          state_d     = S_VS;
        end else if (state_q == S_VS) begin
          cmd_o.mul_s = 1'b1;
          state_d     = S_VR;
        end else begin
          cmd_o.ld_v = 1'b1;
          if (cur != '0) begin
            state_d = S_H1C;
          end else if (last) begin
            state_d = S_H2C;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_H1C, S_H1S, S_H1O: begin
        cmd_o.tap   = sgb_pkg::TAP_H1;
        cmd_o.has_a = (cur >= AddrW'(2));
        cmd_o.has_b = 1'b1;
        if (state_q == S_H1C) begin
          cmd_o.mul_c = 1'b1;
          state_d     = S_H1S;
        end else if (state_q == S_H1S) begin
          cmd_o.mul_s = 1'b1;
          state_d     = S_H1O;
        end else if (sts_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = last ? S_H2C : S_DONE;
        end
      end
      S_H2C, S_H2S, S_H2O: begin
        cmd_o.tap     = sgb_pkg::TAP_H2;
        cmd_o.has_a   = (cur != '0);
        cmd_o.has_b   = 1'b0;
        cmd_o.out_col = cur;
        cmd_o.out_fe  = (kind_q == sgb_pkg::KIND_DRAIN);
        if (state_q == S_H2C) begin
          cmd_o.mul_c = 1'b1;
          state_d     = S_H2S;
        end else if (state_q == S_H2S) begin
          cmd_o.mul_s = 1'b1;
          state_d     = S_H2O;
        end else if (sts_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
        if (kind_q == sgb_pkg::KIND_DRAIN) begin
          if (last) begin
            drain_d        = '0;
            row_d          = '0;
            col_d          = '0;
            cmd_o.hist_clr = 1'b1;
          end else begin
            drain_d          = drain_q + AddrW'(1);
            cmd_o.hist_shift = 1'b1;
          end
        end else begin
          cmd_o.mem_wr     = 1'b1;
          cmd_o.hist_shift = vert_q;
          if (last) begin
            col_d = '0;
            row_d = row_q + RowW'(1);
          end else begin
            col_d = col_q + AddrW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= WW'(sgb_pkg::MaxWidth);
      height_q <= RowW'(256);
      row_q    <= '0;
      col_q    <= '0;
      drain_q  <= '0;
      kind_q   <= sgb_pkg::KIND_PIXEL;
      vert_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      drain_q <= drain_d;
      kind_q  <= kind_d;
      vert_q  <= vert_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sgb_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WW-1:0];
          sgb_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[RowW-1:0];
          default: ;
        endcase
      end
    end
  end

  `ASSERT_CLK(a_load_when_free, clk_i, rst_ni, cmd_o.ld_out |-> sts_i.out_free, "Result loaded over one not yet taken.")
  `ASSERT_CLK(a_done_to_idle, clk_i, rst_ni, (state_q == S_DONE) |=> (state_q == S_IDLE), "Controller did not return to idle after an item.")
  `ASSERT_CLK(a_work_starts, clk_i, rst_ni, (accept && work) |=> (state_q != S_IDLE), "Accepted item started no work.")

endmodule

`default_nettype wire

/* src/separable_gaussian_blur_3tap.sv */
// Streaming separable 3-tap Gaussian blur over a raster-order image of Q8.8 pixels.
// Requests enter on the in channel (valid/ready): a pixel of the frame, or a drain
// tick that flushes the last row once all rows are in. Blurred pixels leave on the
// out channel (valid/ready) with their row, column and an end-of-frame flag.
// Output lags the input by one row; row 0 of a frame gives no result. After it, a
// request on column 0 gives none, one on a later column gives one result, and the
// last column adds one more.
// The block works on one request at a time. It takes an ignored request in idle
// alone, and a row 0 pixel goes on from idle to the done state. Other requests read
// the line buffer in idle, then pass the vertical centre, side and round states, a
// centre, side and output state for each result, and the done state, since each
// 3-tap sum needs a center product and then a side product after the buffer read.
// The result sits in an output register; while the receiver stalls, the block
// holds at the next result and takes no new request.
// Reset clears the counters and column history and sets width and height to 256.
// The line buffers are not cleared. The user must write width and height on the
// config port only while the block is idle; the block itself does not enforce it.
`default_nettype none

module separable_gaussian_blur_3tap (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sgb_pkg::in_req_t             in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output sgb_pkg::out_req_t                 out_req_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [sgb_pkg::CfgDataW-1:0] cfg_data_i
);

  sgb_pkg::cmd_t cmd;
  sgb_pkg::sts_t sts;

  sgb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_kind_i  (in_req_i.kind),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire
